/* src/wcpu_pkg.sv */
`timescale 1ns / 1ps
package wcpu_pkg;

	// memory address width and depth
	localparam int MEM_ADDR_BITS = 16;
	localparam int MEM_WORDS     = 1 << MEM_ADDR_BITS;

	// function codes of an input word
	typedef enum logic [1:0] {
		FN_MEM_WR = 2'd0,
		FN_MEM_RD = 2'd1,
		FN_EXEC   = 2'd2,
		FN_REG_RD = 2'd3
	} func_t;

	// basic opcodes
	typedef enum logic [3:0] {
		OP_NONBASIC = 4'h0,
		OP_SET      = 4'h1,
		OP_ADD      = 4'h2,
		OP_SUB      = 4'h3,
		OP_MUL      = 4'h4,
		OP_DIV      = 4'h5,
		OP_MOD      = 4'h6,
		OP_SHL      = 4'h7,
		OP_SHR      = 4'h8,
		OP_AND      = 4'h9,
		OP_BOR      = 4'ha,
		OP_XOR      = 4'hb,
		OP_IFE      = 4'hc,
		OP_IFN      = 4'hd,
		OP_IFG      = 4'he,
		OP_IFB      = 4'hf
	} opcode_t;

	localparam logic [5:0] EXT_JSR = 6'h01;

	// register file indexes beyond the general registers
	localparam logic [3:0] RIDX_SP = 4'd8;
	localparam logic [3:0] RIDX_PC = 4'd9;
	localparam logic [3:0] RIDX_O  = 4'd10;

	// operand codes with special meaning
	localparam logic [5:0] OPD_POP     = 6'h18;
	localparam logic [5:0] OPD_PEEK    = 6'h19;
	localparam logic [5:0] OPD_PUSH    = 6'h1a;
	localparam logic [5:0] OPD_SP      = 6'h1b;
	localparam logic [5:0] OPD_O       = 6'h1d;
	localparam logic [5:0] OPD_IND_NW  = 6'h1e;
	localparam logic [5:0] OPD_LIT_NW  = 6'h1f;

	// operand location kinds
	typedef enum logic [1:0] {
		LOC_REG = 2'd0,
		LOC_MEM = 2'd1,
		LOC_LIT = 2'd2
	} loc_kind_t;

	typedef struct packed {
		loc_kind_t   kind;
		logic [15:0] val;
	} loc_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MRD,
		ST_FETCH,
		ST_RES,
		ST_RESW,
		ST_RDA,
		ST_RDAW,
		ST_RDB,
		ST_RDBW,
		ST_EXEC,
		ST_DIV,
		ST_WB,
		ST_JSR,
		ST_SKIP,
		ST_SKIPW,
		ST_RESP
	} state_t;

	// operand code takes a word after the instruction
	function automatic logic needs_word(input logic [5:0] c);
		needs_word = (c[5:3] == 3'b010) || (c == OPD_IND_NW) || (c == OPD_LIT_NW);
	endfunction

endpackage

/* src/word_cpu_instruction_step.sv */
`timescale 1ns / 1ps
// memory reads and writes and instructions each end in a result word; an instruction makes
// at most one access a cycle through the single memory port;
// div and mod with a nonzero divisor run in a bit-serial divider
// one word is worked at a time; a new word is taken while the result waits in its register
// reset clears registers, SP, PC and O at once; main memory is not cleared
module word_cpu_instruction_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // func[1:0], addr[17:2], wdata[33:18], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // read_data[15:0], prog_counter[31:16],
	                              // overflow_word[47:32], reserved_op[48], zero fill
);
	import wcpu_pkg::*;

	typedef logic [MEM_ADDR_BITS-1:0] maddr_t;

	state_t state_q, state_d;

	// architectural state
	logic [15:0] gpr_q [8];
	logic [15:0] sp_q, pc_q, ovf_q;

	// memory
	logic [15:0] mem [MEM_WORDS];
	logic        mem_we, mem_re;
	maddr_t      mem_waddr, mem_raddr;
	logic [15:0] mem_wdata, mem_rdata;

	// work registers
	logic [15:0] ins_q, x_q, y_q, rd_q, res_q, ovf_val_q, mod_q;
	logic        b_phase_q, resv_q, ovf_we_q;
	loc_t        la_q, lb_q;
	logic [15:0] rem_q;
	logic [31:0] dvd_q, quot_q;
	logic [4:0]  cnt_q;
	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;

	// decoded fields
	logic [1:0]  in_func;
	logic [15:0] in_addr, in_wdata;
	logic [3:0]  op;
	logic [5:0]  ca, cb, code;
	logic        nonbasic, accept, out_free;

	assign in_func  = s_tdata[1:0];
	assign in_addr  = s_tdata[17:2];
	assign in_wdata = s_tdata[33:18];
	assign op       = ins_q[3:0];
	assign ca       = ins_q[9:4];
	assign cb       = ins_q[15:10];
	assign nonbasic = (op == OP_NONBASIC);
	assign code     = (nonbasic || b_phase_q) ? cb : ca;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// register file read by index
	function automatic logic [15:0] reg_rd(input logic [3:0] i);
		logic [15:0] v;
		v = '0;
		if (i[3] == 1'b0) v = gpr_q[i[2:0]];
		else if (i == RIDX_SP) v = sp_q;
		else if (i == RIDX_PC) v = pc_q;
		else if (i == RIDX_O) v = ovf_q;
		reg_rd = v;
	endfunction

	function automatic logic [15:0] loc_rd(input loc_t l);
		loc_rd = (l.kind == LOC_REG) ? reg_rd(l.val[3:0]) : l.val;
	endfunction

	// memory array, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata <= mem[mem_raddr];
	end

	// operand resolve without an extra word
	loc_t        loc_direct;
	logic        word_op;
	always_comb begin
		loc_direct.kind = LOC_LIT;
		loc_direct.val  = {11'd0, code[4:0]};
		if (code[5:3] == 3'b000) begin
			loc_direct.kind = LOC_REG;
			loc_direct.val  = {10'd0, code};
		end else if (code[5:3] == 3'b001) begin
			loc_direct.kind = LOC_MEM;
			loc_direct.val  = gpr_q[code[2:0]];
		end else if (code == OPD_POP || code == OPD_PEEK) begin
			loc_direct.kind = LOC_MEM;
			loc_direct.val  = sp_q;
		end else if (code == OPD_PUSH) begin
			loc_direct.kind = LOC_MEM;
			loc_direct.val  = sp_q - 16'd1;
		end else if (code >= OPD_SP && code <= OPD_O) begin
			loc_direct.kind = LOC_REG;
			loc_direct.val  = {12'd0, RIDX_SP + 4'(code - OPD_SP)};
		end
		word_op = needs_word(code);
	end

	// operand resolve with the fetched word
	loc_t loc_word;
	always_comb begin
		loc_word.kind = LOC_MEM;
		loc_word.val  = mem_rdata + gpr_q[code[2:0]];
		if (code == OPD_IND_NW) begin
			loc_word.val = mem_rdata;
		end else if (code == OPD_LIT_NW) begin
			loc_word.kind = LOC_LIT;
			loc_word.val  = mem_rdata;
		end
	end

	// combinational alu
	logic [16:0] add_r;
	logic [31:0] mul_r;
	logic [47:0] shl_r;
	logic [31:0] shr_r;
	logic [15:0] alu_res, alu_ovf;
	logic        alu_ovf_we, alu_skip, alu_wr, big_shift;
	always_comb begin
		add_r      = {1'b0, x_q} + {1'b0, y_q};
		mul_r      = x_q * y_q;
		shl_r      = {32'd0, x_q} << y_q[4:0];
		shr_r      = {x_q, 16'd0} >> y_q[4:0];
		big_shift  = (y_q[15:5] != '0);
		alu_res    = '0;
		alu_ovf    = '0;
		alu_ovf_we = 1'b0;
		alu_skip   = 1'b0;
		alu_wr     = 1'b1;
		case (op)
			OP_SET: alu_res = y_q;
			OP_ADD: begin
				alu_res = add_r[15:0]; alu_ovf = {15'd0, add_r[16]}; alu_ovf_we = 1'b1;
			end
			OP_SUB: begin
				alu_res = x_q - y_q; alu_ovf = (x_q < y_q) ? 16'hffff : 16'h0000;
				alu_ovf_we = 1'b1;
			end
			OP_MUL: begin
				alu_res = mul_r[15:0]; alu_ovf = mul_r[31:16]; alu_ovf_we = 1'b1;
			end
			OP_DIV: alu_ovf_we = 1'b1;
			OP_MOD: alu_res = '0;
			OP_SHL: begin
				alu_ovf_we = 1'b1;
				if (!big_shift) begin
					alu_res = shl_r[15:0]; alu_ovf = shl_r[31:16];
				end
			end
			OP_SHR: begin
				alu_ovf_we = 1'b1;
				if (!big_shift) begin
					alu_res = shr_r[31:16]; alu_ovf = shr_r[15:0];
				end
			end
			OP_AND: alu_res = x_q & y_q;
			OP_BOR: alu_res = x_q | y_q;
			OP_XOR: alu_res = x_q ^ y_q;
			OP_IFE: begin alu_wr = 1'b0; alu_skip = (x_q != y_q); end
			OP_IFN: begin alu_wr = 1'b0; alu_skip = (x_q == y_q); end
			OP_IFG: begin alu_wr = 1'b0; alu_skip = (x_q <= y_q); end
			default: begin alu_wr = 1'b0; alu_skip = ((x_q & y_q) == '0); end
		endcase
	end

	logic div_go;
	assign div_go = (op == OP_DIV || op == OP_MOD) && (y_q != '0);

	// one restoring division step
	logic [16:0] trial;
	logic        qbit;
	logic [15:0] rem_n;
	logic [31:0] quot_n;
	always_comb begin
		trial  = {rem_q, dvd_q[31]};
		qbit   = (trial >= {1'b0, y_q});
		rem_n  = qbit ? 16'(trial - {1'b0, y_q}) : trial[15:0];
		quot_n = {quot_q[30:0], qbit};
	end

	// length of the skipped instruction
	logic [15:0] skip_n;
	always_comb begin
		skip_n = 16'd1 + {15'd0, needs_word(mem_rdata[15:10])};
		if (mem_rdata[3:0] != '0) skip_n = skip_n + {15'd0, needs_word(mem_rdata[9:4])};
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func_t'(in_func))
						FN_MEM_RD: state_d = ST_MRD;
						FN_EXEC:   state_d = ST_FETCH;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_MRD:   state_d = ST_RESP;
			ST_FETCH: state_d = ST_RES;
			ST_RES, ST_RESW: begin
				if (state_q == ST_RES && word_op) state_d = ST_RESW;
				else if (nonbasic) state_d = (ca == EXT_JSR) ? ST_RDA : ST_RESP;
				else if (!b_phase_q) state_d = ST_RES;
				else state_d = ST_RDA;
			end
			ST_RDA: begin
				if (la_q.kind == LOC_MEM) state_d = ST_RDAW;
				else state_d = nonbasic ? ST_JSR : ST_RDB;
			end
			ST_RDAW: state_d = nonbasic ? ST_JSR : ST_RDB;
			ST_RDB:  state_d = (lb_q.kind == LOC_MEM) ? ST_RDBW : ST_EXEC;
			ST_RDBW: state_d = ST_EXEC;
			ST_EXEC: begin
				if (div_go) state_d = ST_DIV;
				else if (alu_wr) state_d = ST_WB;
				else state_d = alu_skip ? ST_SKIP : ST_RESP;
			end
			ST_DIV:   state_d = (cnt_q == 5'd31) ? ST_WB : ST_DIV;
			ST_WB:    state_d = ST_RESP;
			ST_JSR:   state_d = ST_RESP;
			ST_SKIP:  state_d = ST_SKIPW;
			ST_SKIPW: state_d = ST_RESP;
			ST_RESP:  state_d = out_free ? ST_IDLE : ST_RESP;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = maddr_t'(in_addr);
		mem_raddr = maddr_t'(pc_q);
		mem_wdata = in_wdata;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (accept && in_func == FN_MEM_WR) mem_we = 1'b1;
				if (accept && in_func == FN_MEM_RD) begin
					mem_re = 1'b1; mem_raddr = maddr_t'(in_addr);
				end
				if (accept && in_func == FN_EXEC) mem_re = 1'b1;
			end
			ST_RES:  mem_re = word_op;
			ST_RDA: begin
				mem_re = 1'b1; mem_raddr = maddr_t'(la_q.val);
			end
			ST_RDB: begin
				mem_re = 1'b1; mem_raddr = maddr_t'(lb_q.val);
			end
			ST_WB: begin
				mem_we    = (la_q.kind == LOC_MEM);
				mem_waddr = maddr_t'(la_q.val);
				mem_wdata = res_q;
			end
			ST_JSR: begin
				mem_we    = 1'b1;
				mem_waddr = maddr_t'(sp_q - 16'd1);
				mem_wdata = pc_q;
			end
			ST_SKIP: mem_re = 1'b1;
			default: ;
		endcase
	end

	// architectural and work registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < 8; i++) gpr_q[i] <= '0;
			sp_q       <= '0;
			pc_q       <= '0;
			ovf_q      <= '0;
			b_phase_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// result register loaded from the response state, freed by the receiver
			if (state_q == ST_RESP && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_q      <= (in_func == FN_REG_RD && in_addr[15:4] == '0) ?
							reg_rd(in_addr[3:0]) : '0;
						resv_q    <= 1'b0;
						b_phase_q <= 1'b0;
						if (in_func == FN_EXEC) pc_q <= pc_q + 16'd1;
					end
				end
				ST_MRD:   rd_q  <= mem_rdata;
				ST_FETCH: ins_q <= mem_rdata;
				ST_RES, ST_RESW: begin
					if (state_q == ST_RES && word_op) begin
						pc_q <= pc_q + 16'd1;
					end else begin
						if (state_q == ST_RES) begin
							if (code == OPD_POP) sp_q <= sp_q + 16'd1;
							if (code == OPD_PUSH) sp_q <= sp_q - 16'd1;
						end
						if (b_phase_q) lb_q <= (state_q == ST_RES) ? loc_direct : loc_word;
						else la_q <= (state_q == ST_RES) ? loc_direct : loc_word;
						b_phase_q <= 1'b1;
						if (nonbasic && ca != EXT_JSR) resv_q <= 1'b1;
					end
				end
				ST_RDA:  x_q <= loc_rd(la_q);
				ST_RDAW: x_q <= mem_rdata;
				ST_RDB:  y_q <= loc_rd(lb_q);
				ST_RDBW: y_q <= mem_rdata;
				ST_EXEC: begin
					res_q     <= alu_res;
					ovf_val_q <= alu_ovf;
					ovf_we_q  <= alu_ovf_we && !(op == OP_DIV && div_go);
					rem_q     <= '0;
					dvd_q     <= {x_q, 16'd0};
					quot_q    <= '0;
					cnt_q     <= '0;
				end
				ST_DIV: begin
					rem_q  <= rem_n;
					dvd_q  <= {dvd_q[30:0], 1'b0};
					quot_q <= quot_n;
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) mod_q <= rem_n;
					if (cnt_q == 5'd31) begin
						res_q     <= (op == OP_DIV) ? quot_n[31:16] : mod_q;
						ovf_val_q <= quot_n[15:0];
						ovf_we_q  <= (op == OP_DIV);
					end
				end
				ST_WB: begin
					if (la_q.kind == LOC_REG) begin
						if (la_q.val[3] == 1'b0) gpr_q[la_q.val[2:0]] <= res_q;
						else if (la_q.val[3:0] == RIDX_SP) sp_q <= res_q;
						else if (la_q.val[3:0] == RIDX_PC) pc_q <= res_q;
						else if (la_q.val[3:0] == RIDX_O && !ovf_we_q) ovf_q <= res_q;
					end
					// overflow written last wins over an O destination
					if (ovf_we_q) ovf_q <= ovf_val_q;
				end
				ST_JSR: begin
					sp_q <= sp_q - 16'd1;
					pc_q <= x_q;
				end
				ST_SKIPW: pc_q <= pc_q + skip_n;
				ST_RESP: begin
					if (out_free) m_tdata_q <= {7'd0, resv_q, ovf_q, pc_q, rd_q};
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a taken word always leaves idle
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE) else $error("accepted word left sequencer idle");

	// divider runs only into write-back
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |=> (state_q == ST_DIV || state_q == ST_WB))
		else $error("divider left early");

	// memory writes only from the states that own them
	a_mem_we: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_WB || state_q == ST_JSR))
		else $error("stray memory write");

	// a new result word comes only from the response state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_RESP))
		else $error("result word raised outside response");

endmodule

/* tb/word_cpu_instruction_step_tb.sv */
`timescale 1ns / 1ps
module word_cpu_instruction_step_tb;
	import wcpu_pkg::*;

	typedef struct {
		bit [15:0] read_data;
		bit [15:0] prog_counter;
		bit [15:0] overflow_word;
		bit        reserved_op;
	} step_word_t;

	// instruction-level model of the core with its own memory image
	class cpu_predictor;
		bit [15:0]  mem [int];
		bit [15:0]  gr [8];
		bit [15:0]  sp, pc, ov;
		bit         probing;
		bit [15:0]  missing[$];
		step_word_t expected_q[$];
		int         mismatches;
		int         checked;

		function cpu_predictor twin();
			twin = new();
			twin.mem = mem;
			twin.gr = gr;
			twin.sp = sp;
			twin.pc = pc;
			twin.ov = ov;
			twin.probing = 1;
		endfunction

		// unwritten words are only recorded while probing
		function bit [15:0] mrd(bit [15:0] a);
			if (!mem.exists(a)) begin
				if (probing) missing.push_back(a);
				return 16'h0;
			end
			return mem[a];
		endfunction

		function void mwr(bit [15:0] a, bit [15:0] v);
			mem[a] = v;
		endfunction

		function bit [15:0] fetch();
			fetch = mrd(pc);
			pc = pc + 16'd1;
		endfunction

		function bit [15:0] rrd(bit [15:0] i);
			if (i < 8) return gr[i[2:0]];
			if (i == RIDX_SP) return sp;
			if (i == RIDX_PC) return pc;
			if (i == RIDX_O) return ov;
			return 16'h0;
		endfunction

		function void rwr(bit [15:0] i, bit [15:0] v);
			if (i < 8) gr[i[2:0]] = v;
			else if (i == RIDX_SP) sp = v;
			else if (i == RIDX_PC) pc = v;
			else if (i == RIDX_O) ov = v;
		endfunction

		// operand code to location, with its pc and sp side effects
		function void resolve(bit [5:0] c, output loc_kind_t k, output bit [15:0] v);
			bit [15:0] w;
			if (c < 6'h08) begin
				k = LOC_REG; v = 16'(c);
			end else if (c < 6'h10) begin
				k = LOC_MEM; v = gr[c[2:0]];
			end else if (c < OPD_POP) begin
				w = fetch();
				k = LOC_MEM; v = w + gr[c[2:0]];
			end else if (c == OPD_POP) begin
				k = LOC_MEM; v = sp; sp = sp + 16'd1;
			end else if (c == OPD_PEEK) begin
				k = LOC_MEM; v = sp;
			end else if (c == OPD_PUSH) begin
				sp = sp - 16'd1; k = LOC_MEM; v = sp;
			end else if (c <= OPD_O) begin
				k = LOC_REG; v = 16'd8 + 16'(c) - 16'(OPD_SP);
			end else if (c == OPD_IND_NW) begin
				k = LOC_MEM; v = fetch();
			end else if (c == OPD_LIT_NW) begin
				k = LOC_LIT; v = fetch();
			end else begin
				k = LOC_LIT; v = 16'(c - 6'h20);
			end
		endfunction

		function bit [15:0] lrd(loc_kind_t k, bit [15:0] v);
			if (k == LOC_REG) return rrd(v);
			if (k == LOC_MEM) return mrd(v);
			return v;
		endfunction

		function void lwr(loc_kind_t k, bit [15:0] v, bit [15:0] d);
			if (k == LOC_REG) rwr(v, d);
			else if (k == LOC_MEM) mwr(v, d);
		endfunction

		function int extra(bit [5:0] c);
			return ((c >= 6'h10 && c <= 6'h17) || c == OPD_IND_NW || c == OPD_LIT_NW) ? 1 : 0;
		endfunction

		// a failed test steps over the next instruction and its operand words
		function void skip_next();
			bit [15:0] w;
			int n;
			w = mrd(pc);
			n = 1 + extra(w[15:10]);
			if (w[3:0] != 4'h0) n += extra(w[9:4]);
			pc = pc + 16'(n);
		endfunction

		function bit execute();
			bit [15:0]  ins;
			opcode_t    op;
			bit [5:0]   ca, cb;
			loc_kind_t  ka, kb;
			bit [15:0]  va, vb;
			bit [31:0]  x, y, r;
			bit [63:0]  t;
			bit         skip;
			ins = fetch();
			op = opcode_t'(ins[3:0]);
			ca = ins[9:4];
			cb = ins[15:10];
			skip = 0;
			if (op == OP_NONBASIC) begin
				resolve(cb, ka, va);
				if (ca != EXT_JSR) return 1;
				x = lrd(ka, va);
				sp = sp - 16'd1;
				mwr(sp, pc);
				pc = x[15:0];
				return 0;
			end
			resolve(ca, ka, va);
			resolve(cb, kb, vb);
			x = lrd(ka, va);
			y = lrd(kb, vb);
			case (op)
				OP_SET: lwr(ka, va, y[15:0]);
				OP_ADD: begin
					r = x + y; lwr(ka, va, r[15:0]); ov = r[31:16];
				end
				OP_SUB: begin
					r = x - y; lwr(ka, va, r[15:0]); ov = (x < y) ? 16'hffff : 16'h0;
				end
				OP_MUL: begin
					r = x * y; lwr(ka, va, r[15:0]); ov = r[31:16];
				end
				OP_DIV: begin
					if (y == 0) begin
						lwr(ka, va, 16'h0); ov = 16'h0;
					end else begin
						r = x / y; lwr(ka, va, r[15:0]);
						r = (x << 16) / y; ov = r[15:0];
					end
				end
				OP_MOD: begin
					r = (y == 0) ? 0 : x % y; lwr(ka, va, r[15:0]);
				end
				OP_SHL: begin
					if (y >= 32) begin
						lwr(ka, va, 16'h0); ov = 16'h0;
					end else begin
						t = 64'(x) << y; lwr(ka, va, t[15:0]); ov = t[31:16];
					end
				end
				OP_SHR: begin
					if (y >= 32) begin
						lwr(ka, va, 16'h0); ov = 16'h0;
					end else begin
						t = (64'(x) << 16) >> y; lwr(ka, va, t[31:16]); ov = t[15:0];
					end
				end
				OP_AND: lwr(ka, va, x[15:0] & y[15:0]);
				OP_BOR: lwr(ka, va, x[15:0] | y[15:0]);
				OP_XOR: lwr(ka, va, x[15:0] ^ y[15:0]);
				OP_IFE: skip = (x != y);
				OP_IFN: skip = (x == y);
				OP_IFG: skip = (x <= y);
				default: skip = ((x & y) == 0);
			endcase
			if (skip) skip_next();
			return 0;
		endfunction

		// accepted input word: advance the model and queue its result
		function void note_input(func_t f, bit [15:0] a, bit [15:0] d);
			step_word_t e;
			e = '{16'h0, 16'h0, 16'h0, 1'b0};
			case (f)
				FN_MEM_WR: mwr(a, d);
				FN_MEM_RD: e.read_data = mrd(a);
				FN_EXEC:   e.reserved_op = execute();
				default:   e.read_data = rrd(a);
			endcase
			e.prog_counter = pc;
			e.overflow_word = ov;
			expected_q.push_back(e);
		endfunction

		function void check_result(bit [55:0] t);
			step_word_t e;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", t);
				return;
			end
			e = expected_q.pop_front();
			if (t[15:0] != e.read_data || t[31:16] != e.prog_counter ||
			    t[47:32] != e.overflow_word || t[48] != e.reserved_op) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch at result %0d: exp rd %h pc %h o %h rsv %b,",
						" got rd %h pc %h o %h rsv %b"},
						checked, e.read_data, e.prog_counter, e.overflow_word, e.reserved_op,
						t[15:0], t[31:16], t[47:32], t[48]);
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEM_TARGET    = 950;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;

	cpu_predictor model;
	bit           idle_on = 1;
	int           hold_left = 0;
	int           stall_cycles = 0;
	int           exec_count = 0;
	int           sent_count = 0;
	bit [15:0]    written_log[$];

	word_cpu_instruction_step dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// result side: check, then decide ready for the next edge
	initial begin
		m_tready = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) model.check_result(m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(0, 99) < 16);
			end
		end
	end

	// watchdog on cycles with no handshake
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("word_cpu_instruction_step_tb failed");
				$finish;
			end
		end
	end

	function automatic bit [15:0] enc(opcode_t o, bit [5:0] a, bit [5:0] b);
		return {b, a, o};
	endfunction

	task automatic send_word(func_t f, bit [15:0] a, bit [15:0] d);
		while (idle_on && $urandom_range(0, 99) < 16) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {6'b0, d, a, f};
		do @(posedge clk); while (!s_tready);
		model.note_input(f, a, d);
		sent_count++;
		if (f == FN_MEM_WR) written_log.push_back(a);
		if (f == FN_EXEC) exec_count++;
	endtask

	// fill every word the next instruction would read, then execute it
	task automatic exec_ready();
		cpu_predictor p;
		bit r;
		forever begin
			p = model.twin();
			r = p.execute();
			if (p.missing.size() == 0) break;
			foreach (p.missing[i])
				if (!model.mem.exists(p.missing[i]))
					send_word(FN_MEM_WR, p.missing[i], 16'($urandom));
		end
		send_word(FN_EXEC, 16'h0, 16'($urandom));
	endtask

	task automatic run_prog(input bit [15:0] w[$]);
		bit [15:0] at;
		at = model.pc;
		foreach (w[i]) send_word(FN_MEM_WR, at + 16'(i), w[i]);
		exec_ready();
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		while (model.expected_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		bit [15:0] ins;
		bit [5:0]  ca;
		int        r;
		int        iter;
		model = new();
		s_tvalid = 0;
		s_tdata = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: literals, overflow, zero divisors, large shifts, stack,
		// indexed addressing, literal and O destinations, skips, jsr, reserved
		run_prog('{enc(OP_SET, 6'h00, OPD_LIT_NW), 16'hffff});
		run_prog('{enc(OP_SET, 6'h01, 6'h3f)});
		run_prog('{enc(OP_ADD, 6'h00, 6'h01)});
		run_prog('{enc(OP_ADD, OPD_O, 6'h00)});
		run_prog('{enc(OP_MUL, 6'h00, OPD_LIT_NW), 16'hffff});
		run_prog('{enc(OP_DIV, 6'h00, 6'h20)});
		run_prog('{enc(OP_MOD, 6'h01, 6'h20)});
		run_prog('{enc(OP_SET, 6'h02, OPD_LIT_NW), 16'h8000});
		run_prog('{enc(OP_DIV, 6'h02, 6'h01)});
		run_prog('{enc(OP_SHL, 6'h02, OPD_LIT_NW), 16'd40});
		run_prog('{enc(OP_SHR, 6'h01, 6'h23)});
		run_prog('{enc(OP_SHL, 6'h01, 6'h24)});
		run_prog('{enc(OP_SUB, 6'h02, 6'h21)});
		run_prog('{enc(OP_AND, 6'h01, 6'h3f)});
		run_prog('{enc(OP_BOR, 6'h03, OPD_LIT_NW), 16'h1200});
		run_prog('{enc(OP_XOR, 6'h03, 6'h01)});
		run_prog('{enc(OP_SET, 6'h3f, 6'h03)});
		run_prog('{enc(OP_SET, OPD_PUSH, 6'h03)});
		run_prog('{enc(OP_SET, 6'h04, OPD_POP)});
		run_prog('{enc(OP_SET, 6'h13, OPD_PEEK), 16'h0100});
		run_prog('{enc(OP_SET, OPD_IND_NW, OPD_SP), 16'h0200});
		run_prog('{enc(OP_IFE, 6'h03, 6'h25), enc(OP_SET, 6'h10, OPD_LIT_NW), 16'h3, 16'h4});
		run_prog('{enc(OP_IFN, 6'h03, 6'h03), enc(OP_ADD, 6'h00, 6'h21)});
		run_prog('{enc(OP_IFG, 6'h20, 6'h03), enc(OP_ADD, 6'h00, 6'h21)});
		run_prog('{enc(OP_IFB, 6'h03, 6'h20), enc(OP_ADD, 6'h00, 6'h21)});
		run_prog('{enc(OP_NONBASIC, EXT_JSR, OPD_LIT_NW), 16'h0040});
		run_prog('{enc(OP_NONBASIC, 6'h02, OPD_POP)});
		for (int i = 0; i <= 11; i++) send_word(FN_REG_RD, i[15:0], 16'h0);

		// random: mostly fresh instructions at pc, plus raw memory and register traffic
		iter = 0;
		while (sent_count < ITEM_TARGET) begin
			idle_on = !(iter >= 40 && iter < 80);
			if (iter == 80) hold_left = 400;
			if (iter == 160) wait_drained();
			r = $urandom_range(0, 99);
			if (r < 55) begin
				ca = 6'($urandom);
				if (($urandom & 1) == 0) ca = EXT_JSR;
				ins = {6'($urandom), 6'($urandom), 4'($urandom)};
				if (ins[3:0] == OP_NONBASIC) ins[9:4] = ca;
				run_prog('{ins, 16'($urandom), 16'($urandom)});
			end else if (r < 65) begin
				exec_ready();
			end else if (r < 78) begin
				send_word(FN_MEM_WR, 16'($urandom), 16'($urandom));
			end else if (r < 88) begin
				send_word(FN_MEM_RD, written_log[$urandom_range(0, written_log.size() - 1)],
					16'($urandom));
			end else begin
				send_word(FN_REG_RD, ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 10))
					: 16'($urandom), 16'($urandom));
			end
			iter++;
		end
		idle_on = 1;

		wait_drained();
		repeat (60) @(posedge clk);
		if (model.expected_q.size() != 0) model.mismatches++;
		$display("covered %0d result words, %0d of them from executed instructions,", model.checked,
			exec_count);
		$display("with %0d distinct memory words written and %0d mismatches", model.mem.num(),
			model.mismatches);
		if (model.mismatches == 0)
			$display("word_cpu_instruction_step_tb passed");
		else
			$display("word_cpu_instruction_step_tb failed");
		$finish;
	end

endmodule
